FILE: rtl/cps_pkg.sv
// Package for the circle pair separation unit: payload structs, widths
// and the saturation helper. No dependencies.
package cps_pkg;

    localparam int CW   = 24;
    localparam int RW   = 16;
    localparam int DW   = RW + 1;
    localparam int DXW  = CW + 1;
    localparam int MW   = DW;
    localparam int SQW  = 2 * MW;
    localparam int RADW = SQW + 16;
    localparam int REMW = RADW + 2;
    localparam int LW   = RADW / 2;
    localparam int GW   = DW + 8;
    localparam int PW   = MW + GW;
    localparam int NW   = PW + 6;
    localparam int DENW = LW + 6;
    localparam int QW   = DW;
    localparam logic [RW-1:0] RADIUS_RESET = RW'(1280);

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
    } cps_in_t;

    typedef struct packed {
        logic signed [CW-1:0] new_first_x;
        logic signed [CW-1:0] new_first_y;
        logic signed [CW-1:0] new_second_x;
        logic signed [CW-1:0] new_second_y;
        logic                 overlapped;
    } cps_out_t;

    typedef struct packed {
        cps_in_t         pos;
        logic [MW-1:0]   mag_x;
        logic [MW-1:0]   mag_y;
        logic            neg_x;
        logic            neg_y;
        logic [DW-1:0]   diam;
        logic            hit;
    } cps_side_t;

    typedef struct packed {
        cps_side_t       side;
        logic [REMW-1:0] rem;
        logic [LW-1:0]   root;
    } cps_sq_t;

    typedef struct packed {
        cps_side_t       side;
        logic [DENW-1:0] den;
        logic [NW-1:0]   rem_x;
        logic [NW-1:0]   rem_y;
        logic [QW-1:0]   quo_x;
        logic [QW-1:0]   quo_y;
    } cps_dv_t;

    function automatic logic signed [CW-1:0] sat(input logic signed [DXW:0] v);
        logic signed [DXW:0] hi;
        logic signed [DXW:0] lo;
        hi = (DXW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
        lo = -hi - (DXW+1)'(1);
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage

FILE: rtl/cps_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
// Depends on cps_pkg.
module cps_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cps_pkg::cps_sq_t in_data,
    output logic            out_valid,
    output cps_pkg::cps_sq_t out_data
);
    logic             valid_reg;
    cps_pkg::cps_sq_t data_reg;
    cps_pkg::cps_sq_t data_next;
    logic [cps_pkg::REMW-1:0] trial;

    always_comb begin
        trial = (cps_pkg::REMW'(in_data.root) << (BIT + 1))
              + (cps_pkg::REMW'(1) << (2 * BIT));
        data_next = in_data;
        if (in_data.rem >= trial) begin
            data_next.rem       = in_data.rem - trial;
            data_next.root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: rtl/cps_div_cell.sv
// One cell of the divider chain: settles one quotient bit per axis.
// Depends on cps_pkg.
module cps_div_cell #(
    parameter int BIT = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cps_pkg::cps_dv_t in_data,
    output logic            out_valid,
    output cps_pkg::cps_dv_t out_data
);
    logic             valid_reg;
    cps_pkg::cps_dv_t data_reg;
    cps_pkg::cps_dv_t data_next;
    logic [cps_pkg::NW-1:0] dsh;

    always_comb begin
        dsh = cps_pkg::NW'(in_data.den) << BIT;
        data_next = in_data;
        if (in_data.rem_x >= dsh) begin
            data_next.rem_x      = in_data.rem_x - dsh;
            data_next.quo_x[BIT] = 1'b1;
        end
        if (in_data.rem_y >= dsh) begin
            data_next.rem_y      = in_data.rem_y - dsh;
            data_next.quo_y[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: rtl/circle_pair_separation_unit.sv
// Top level of the circle pair separation unit: front stages, square root
// and divider cell chains, output register. Depends on cps_pkg and the cells.
//
//   channel | direction | payload
//   s_      | in        | cps_in_t, two circle centres
//   m_      | out       | cps_out_t, corrected centres and contact flag
//   cfg_    | in        | particle radius, 16 bits
//
// One pair per cycle unless the output stalls. It has 25 root cells and 17
// quotient cells plus seven other stages. Reset clears all stage valid bits
// and loads the default radius. Each stage moves when it is empty or the
// next one moves, so bubbles close up while the output waits.
module circle_pair_separation_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cps_pkg::cps_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cps_pkg::cps_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [cps_pkg::RW-1:0] cfg_data
);
    localparam int SQ0  = 3;
    localparam int SD   = SQ0 + cps_pkg::LW;
    localparam int SE   = SD + 1;
    localparam int SF   = SE + 1;
    localparam int DV0  = SF + 1;
    localparam int SG   = DV0 + cps_pkg::QW;
    localparam int NSTG = SG + 1;

    logic [cps_pkg::RW-1:0] radius_reg;
    logic [NSTG-1:0] stg_v;
    logic [NSTG-1:0] adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= cps_pkg::RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    always_comb begin
        adv[NSTG-1] = !stg_v[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !stg_v[k] || adv[k+1];
        end
    end
    assign s_ready = adv[0];

    // Stage A: differences and range check.
    logic signed [cps_pkg::DXW-1:0] dx;
    logic signed [cps_pkg::DXW-1:0] dy;
    logic signed [cps_pkg::DXW:0]   dme;
    logic signed [cps_pkg::DXW:0]   dxe;
    logic signed [cps_pkg::DXW:0]   dye;
    logic [cps_pkg::DW-1:0]         diam;
    cps_pkg::cps_side_t a_next;
    cps_pkg::cps_side_t a_reg;
    logic a_v_reg;

    always_comb begin
        diam = {radius_reg, 1'b0};
        dx   = cps_pkg::DXW'(s_data.second_x) - cps_pkg::DXW'(s_data.first_x);
        dy   = cps_pkg::DXW'(s_data.second_y) - cps_pkg::DXW'(s_data.first_y);
        dxe  = (cps_pkg::DXW+1)'(dx);
        dye  = (cps_pkg::DXW+1)'(dy);
        dme  = signed'({{(cps_pkg::DXW+1-cps_pkg::DW){1'b0}}, diam});
        a_next.pos   = s_data;
        a_next.neg_x = dx[cps_pkg::DXW-1];
        a_next.neg_y = dy[cps_pkg::DXW-1];
        a_next.mag_x = dx[cps_pkg::DXW-1] ? cps_pkg::MW'(-dx) : cps_pkg::MW'(dx);
        a_next.mag_y = dy[cps_pkg::DXW-1] ? cps_pkg::MW'(-dy) : cps_pkg::MW'(dy);
        a_next.diam  = diam;
        a_next.hit   = (dxe < dme) && (dxe > -dme) && (dye < dme) && (dye > -dme);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (adv[0]) begin
            a_v_reg <= s_valid;
        end
        if (adv[0]) begin
            a_reg <= a_next;
        end
    end

    // Stage B: squares.
    cps_pkg::cps_side_t b_reg;
    logic b_v_reg;
    logic [cps_pkg::SQW-1:0] sqx_reg, sqy_reg, dd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (adv[1]) begin
            b_v_reg <= a_v_reg;
        end
        if (adv[1]) begin
            b_reg   <= a_reg;
            sqx_reg <= a_reg.mag_x * a_reg.mag_x;
            sqy_reg <= a_reg.mag_y * a_reg.mag_y;
            dd_reg  <= a_reg.diam * a_reg.diam;
        end
    end

    // Stage C: squared distance compare, radicand setup.
    logic [cps_pkg::SQW:0] qsum;
    cps_pkg::cps_sq_t c_next;
    cps_pkg::cps_sq_t sq_d [0:cps_pkg::LW];
    logic             sq_v [0:cps_pkg::LW];

    always_comb begin
        qsum = (cps_pkg::SQW+1)'(sqx_reg) + (cps_pkg::SQW+1)'(sqy_reg);
        c_next.side     = b_reg;
        c_next.side.hit = b_reg.hit && (qsum != '0)
                        && (qsum < (cps_pkg::SQW+1)'(dd_reg));
        c_next.rem      = cps_pkg::REMW'({qsum[cps_pkg::SQW-1:0], 16'd0});
        c_next.root     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v[0] <= 1'b0;
        end else if (adv[2]) begin
            sq_v[0] <= b_v_reg;
        end
        if (adv[2]) begin
            sq_d[0] <= c_next;
        end
    end

    for (genvar k = 0; k < cps_pkg::LW; k++) begin : g_sqrt
        cps_sqrt_cell #(.BIT(cps_pkg::LW - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv[SQ0+k]),
            .in_valid  (sq_v[k]),
            .in_data   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_data  (sq_d[k+1])
        );
    end

    // Stage D: gap to the diameter.
    cps_pkg::cps_side_t d_reg;
    logic d_v_reg;
    logic [cps_pkg::LW-1:0] l_d_reg;
    logic [cps_pkg::GW-1:0] g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (adv[SD]) begin
            d_v_reg <= sq_v[cps_pkg::LW];
        end
        if (adv[SD]) begin
            d_reg   <= sq_d[cps_pkg::LW].side;
            l_d_reg <= sq_d[cps_pkg::LW].root;
            g_reg   <= {sq_d[cps_pkg::LW].side.diam, 8'd0}
                     - cps_pkg::GW'(sq_d[cps_pkg::LW].root);
        end
    end

    // Stage E: products.
    cps_pkg::cps_side_t e_reg;
    logic e_v_reg;
    logic [cps_pkg::LW-1:0] l_e_reg;
    logic [cps_pkg::PW-1:0] px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_v_reg <= 1'b0;
        end else if (adv[SE]) begin
            e_v_reg <= d_v_reg;
        end
        if (adv[SE]) begin
            e_reg   <= d_reg;
            l_e_reg <= l_d_reg;
            px_reg  <= d_reg.mag_x * g_reg;
            py_reg  <= d_reg.mag_y * g_reg;
        end
    end

    // Stage F: rounding numerators and divisor.
    cps_pkg::cps_dv_t f_next;
    cps_pkg::cps_dv_t dv_d [0:cps_pkg::QW];
    logic             dv_v [0:cps_pkg::QW];
    logic [cps_pkg::NW-1:0] l20;

    always_comb begin
        l20 = (cps_pkg::NW'(l_e_reg) << 4) + (cps_pkg::NW'(l_e_reg) << 2);
        f_next.side  = e_reg;
        f_next.den   = (cps_pkg::DENW'(l_e_reg) << 5) + (cps_pkg::DENW'(l_e_reg) << 3);
        f_next.rem_x = (cps_pkg::NW'(px_reg) << 4) - (cps_pkg::NW'(px_reg) << 1) + l20;
        f_next.rem_y = (cps_pkg::NW'(py_reg) << 4) - (cps_pkg::NW'(py_reg) << 1) + l20;
        f_next.quo_x = '0;
        f_next.quo_y = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v[0] <= 1'b0;
        end else if (adv[SF]) begin
            dv_v[0] <= e_v_reg;
        end
        if (adv[SF]) begin
            dv_d[0] <= f_next;
        end
    end

    for (genvar k = 0; k < cps_pkg::QW; k++) begin : g_div
        cps_div_cell #(.BIT(cps_pkg::QW - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv[DV0+k]),
            .in_valid  (dv_v[k]),
            .in_data   (dv_d[k]),
            .out_valid (dv_v[k+1]),
            .out_data  (dv_d[k+1])
        );
    end

    // Stage G: apply shifts, saturate, output register.
    cps_pkg::cps_dv_t  fin;
    cps_pkg::cps_out_t m_next;
    cps_pkg::cps_out_t m_data_reg;
    logic m_v_reg;
    logic signed [cps_pkg::DXW:0] qxe, qye;

    always_comb begin
        fin = dv_d[cps_pkg::QW];
        qxe = signed'((cps_pkg::DXW+1)'(fin.quo_x));
        qye = signed'((cps_pkg::DXW+1)'(fin.quo_y));
        if (fin.side.neg_x) begin
            qxe = -qxe;
        end
        if (fin.side.neg_y) begin
            qye = -qye;
        end
        m_next.new_first_x  = fin.side.pos.first_x;
        m_next.new_first_y  = fin.side.pos.first_y;
        m_next.new_second_x = fin.side.pos.second_x;
        m_next.new_second_y = fin.side.pos.second_y;
        m_next.overlapped   = fin.side.hit;
        if (fin.side.hit) begin
            m_next.new_first_x  = cps_pkg::sat((cps_pkg::DXW+1)'(fin.side.pos.first_x) - qxe);
            m_next.new_first_y  = cps_pkg::sat((cps_pkg::DXW+1)'(fin.side.pos.first_y) - qye);
            m_next.new_second_x = cps_pkg::sat((cps_pkg::DXW+1)'(fin.side.pos.second_x) + qxe);
            m_next.new_second_y = cps_pkg::sat((cps_pkg::DXW+1)'(fin.side.pos.second_y) + qye);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (adv[SG]) begin
            m_v_reg <= dv_v[cps_pkg::QW];
        end
        if (adv[SG]) begin
            m_data_reg <= m_next;
        end
    end
    assign m_valid = m_v_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stg_v[0] = a_v_reg;
        stg_v[1] = b_v_reg;
        stg_v[2] = sq_v[0];
        for (int k = 0; k < cps_pkg::LW; k++) begin
            stg_v[SQ0+k] = sq_v[k+1];
        end
        stg_v[SD] = d_v_reg;
        stg_v[SE] = e_v_reg;
        stg_v[SF] = dv_v[0];
        for (int k = 0; k < cps_pkg::QW; k++) begin
            stg_v[DV0+k] = dv_v[k+1];
        end
        stg_v[SG] = m_v_reg;
    end
endmodule

FILE: rtl/cps_checker.sv
// Port checker for the circle pair separation unit, bound to the top level.
// Depends on cps_pkg.
module cps_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input cps_pkg::cps_out_t m_data,
    input logic              cfg_ready
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled transfer changed");
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("config port not ready");
endmodule

bind circle_pair_separation_unit cps_checker u_cps_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
